// ===== rtl/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// shared widths, control types and helpers for the catmull-rom curve sampler
// ----------------------------------------------------------------------------
package cmr_pkg;

    localparam int COORD_W = 32;
    localparam int ACC_W   = 38;   // coefficient / horner accumulator width
    localparam int T_W     = 17;   // t in units of 2^-16, 0..65536
    localparam int SEG_W   = 6;
    localparam int PADDR_W = 3;

    localparam logic [SEG_W-1:0] SEG_RST = SEG_W'(16);
    localparam logic             REG_SEGMENT_COUNT = 1'b0;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } t_mac_ctl;

    function automatic logic signed [ACC_W-1:0] sext_coord(input logic [COORD_W-1:0] p);
        sext_coord = $signed({{(ACC_W-COORD_W){p[COORD_W-1]}}, p});
    endfunction

    // floor((a + 1) / 2) saturated to the signed 32-bit range
    function automatic logic [COORD_W-1:0] sat_half(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W:0] smax;
        logic signed [ACC_W:0] smin;
        smax = $signed({{(ACC_W+1-COORD_W){1'b0}}, {1'b0, {(COORD_W-1){1'b1}}}});
        smin = ~smax;
        s = $signed({a[ACC_W-1], a}) + $signed((ACC_W+1)'(1));
        s = s >>> 1;
        if (s > smax) begin
            sat_half = smax[COORD_W-1:0];
        end else if (s < smin) begin
            sat_half = smin[COORD_W-1:0];
        end else begin
            sat_half = s[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/cmr_ifs.sv =====
// ----------------------------------------------------------------------------
// cmr_ifs
// valid/ready channels for control points and curve samples
// ----------------------------------------------------------------------------
interface cmr_point_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic        start_curve;

    modport source (output valid, point_x, point_y, point_z, start_curve, input ready);
    modport sink   (input valid, point_x, point_y, point_z, start_curve, output ready);
endinterface

interface cmr_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_x;
    logic [31:0] sample_y;
    logic [31:0] sample_z;
    logic        last_sample;

    modport source (output valid, sample_x, sample_y, sample_z, last_sample, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, last_sample, output ready);
endinterface

// ===== rtl/cmr_tdiv.sv =====
// ----------------------------------------------------------------------------
// cmr_tdiv
// serial restoring divider for 65536 / n, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cmr_tdiv import cmr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SEG_W-1:0] i_den,
    output logic [T_W-1:0]   o_quo,
    output logic [SEG_W-1:0] o_rem,
    output logic             o_done
);

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_idx;
    logic [SEG_W-1:0] r_den;
    logic [SEG_W-1:0] r_rem;
    logic [T_W-1:0]   r_quo;

    logic [SEG_W:0]   n_trial;
    logic             n_ge;

    // dividend is 1 << 16, so only the top bit is set
    assign n_trial = {r_rem, (r_idx == 5'(T_W-1))};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= 5'(T_W-1);
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[T_W-2:0], n_ge};
                r_rem <= n_ge ? SEG_W'(n_trial - {1'b0, r_den}) : n_trial[SEG_W-1:0];
                r_idx <= r_idx - 5'd1;
                if (r_idx == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== rtl/cmr_mac.sv =====
// ----------------------------------------------------------------------------
// cmr_mac
// shared horner step: acc = round(acc * t) + coef, multiply and add in turn
// ----------------------------------------------------------------------------
module cmr_mac import cmr_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [ACC_W-1:0] i_coef,
    input  logic [T_W-1:0]          i_t,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam int PROD_W = ACC_W + T_W + 1;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] n_rnd;

    assign n_prod = r_acc * $signed({1'b0, i_t});
    // round half up, then drop the 16 fraction bits
    assign n_rnd  = (r_prod + $signed(PROD_W'(32768))) >>> 16;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_coef;
        end else if (i_ctl.add) begin
            r_acc <= n_rnd[ACC_W-1:0] + i_coef;
        end
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/catmull_rom_curve_points.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_points
// uniform catmull-rom segment sampler over a sliding window of 3d points
// ----------------------------------------------------------------------------
// a point that completes a window of four starts a setup phase (serial
// 65536/n divider) and then n+1 samples, each made of three axes, each three
// multiply/add steps on the one shared multiplier, plus an output state
// that waits for ready; other points only shift into the window
// synchronous active-low reset clears control state, segment_count reads 16
// ----------------------------------------------------------------------------
module catmull_rom_curve_points import cmr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cmr_point_if.sink           i_pt,
    cmr_sample_if.source        o_smp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_LOAD, S_MUL, S_ADD, S_SAVE, S_EMIT
    } t_state;

    t_state                  r_state;
    logic [SEG_W-1:0]        r_seg;
    logic [1:0]              r_held;
    logic [COORD_W-1:0]      r_win [3][3];   // [axis][oldest..newest]
    logic [COORD_W-1:0]      r_new [3];
    logic signed [ACC_W-1:0] r_e   [3][4];   // [axis][e0..e3]
    logic [COORD_W-1:0]      r_smp [3];
    logic                    r_oval;
    logic [1:0]              r_cnt;
    logic [1:0]              r_ax;
    logic [1:0]              r_k;
    logic [SEG_W-1:0]        r_j;
    logic [SEG_W-1:0]        r_n;
    logic [T_W-1:0]          r_t;
    logic [SEG_W-1:0]        r_trem;
    logic [T_W-1:0]          r_qd;
    logic [SEG_W-1:0]        r_rd;

    logic                    n_acc_in;
    logic [1:0]              n_held;
    logic [SEG_W-1:0]        n_n;
    logic [1:0]              n_csel;
    logic signed [ACC_W-1:0] n_coef;
    logic signed [ACC_W-1:0] n_p0, n_p1, n_p2, n_p3, n_d12;
    logic [SEG_W:0]          n_sum;
    logic [T_W-1:0]          n_quo;
    logic [SEG_W-1:0]        n_rem;
    logic                    n_div_done;
    logic signed [ACC_W-1:0] n_acc;
    t_mac_ctl                n_ctl;
    logic [COORD_W-1:0]      n_pin [3];

    assign n_pin[0] = i_pt.point_x;
    assign n_pin[1] = i_pt.point_y;
    assign n_pin[2] = i_pt.point_z;

    assign i_pt.ready = (r_state == S_IDLE);
    assign n_acc_in   = i_pt.valid && i_pt.ready;
    assign n_held     = i_pt.start_curve ? 2'd0 : r_held;
    assign n_n        = (r_seg == '0) ? SEG_W'(1) : r_seg;

    // points of the axis picked by the prep counter
    assign n_p0  = sext_coord(r_win[r_cnt][0]);
    assign n_p1  = sext_coord(r_win[r_cnt][1]);
    assign n_p2  = sext_coord(r_win[r_cnt][2]);
    assign n_p3  = sext_coord(r_new[r_cnt]);
    assign n_d12 = n_p1 - n_p2;

    assign n_csel = (r_state == S_LOAD) ? 2'd3 : 2'(2'd2 - r_k);
    assign n_coef = r_e[r_ax][n_csel];
    assign n_sum  = {1'b0, r_trem} + {1'b0, r_rd};

    assign n_ctl.load = (r_state == S_LOAD);
    assign n_ctl.mul  = (r_state == S_MUL);
    assign n_ctl.add  = (r_state == S_ADD);

    cmr_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_acc_in && (n_held == 2'd3)),
        .i_den   (n_n),
        .o_quo   (n_quo),
        .o_rem   (n_rem),
        .o_done  (n_div_done)
    );

    cmr_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (n_ctl),
        .i_coef (n_coef),
        .i_t    (r_t),
        .o_acc  (n_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= SEG_RST;
            r_held  <= 2'd0;
            r_oval  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr[2] == REG_SEGMENT_COUNT)) begin
                r_seg <= pwdata[SEG_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (n_acc_in) begin
                        for (int a = 0; a < 3; a++) begin
                            r_new[a] <= n_pin[a];
                        end
                        if (n_held == 2'd3) begin
                            r_state <= S_PREP;
                            r_held  <= 2'd3;
                            r_cnt   <= 2'd0;
                            r_n     <= n_n;
                            r_j     <= '0;
                            r_t     <= '0;
                            r_trem  <= n_n >> 1;
                        end else begin
                            for (int a = 0; a < 3; a++) begin
                                r_win[a][0] <= r_win[a][1];
                                r_win[a][1] <= r_win[a][2];
                                r_win[a][2] <= n_pin[a];
                            end
                            r_held <= n_held + 2'd1;
                        end
                    end
                end
                S_PREP: begin
                    if (r_cnt != 2'd3) begin
                        r_e[r_cnt][0] <= n_p1 <<< 1;
                        r_e[r_cnt][1] <= n_p2 - n_p0;
                        r_e[r_cnt][2] <= (n_p0 <<< 1) + (n_p2 <<< 2)
                                         - ((n_p1 <<< 2) + n_p1) - n_p3;
                        r_e[r_cnt][3] <= (n_d12 <<< 1) + n_d12 + n_p3 - n_p0;
                        r_cnt <= r_cnt + 2'd1;
                    end
                    if (n_div_done) begin
                        // coefficients are captured, the window can move on
                        for (int a = 0; a < 3; a++) begin
                            r_win[a][0] <= r_win[a][1];
                            r_win[a][1] <= r_win[a][2];
                            r_win[a][2] <= r_new[a];
                        end
                        r_qd    <= n_quo;
                        r_rd    <= n_rem;
                        r_ax    <= 2'd0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_k     <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_SAVE : S_MUL;
                end
                S_SAVE: begin
                    r_smp[r_ax] <= sat_half(n_acc);
                    if (r_ax == 2'd2) begin
                        r_oval  <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    if (o_smp.ready) begin
                        r_oval <= 1'b0;
                        if (r_j == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            // t advances by 65536/n with the remainder carried
                            if (n_sum >= {1'b0, r_n}) begin
                                r_t    <= r_t + r_qd + T_W'(1);
                                r_trem <= SEG_W'(n_sum - {1'b0, r_n});
                            end else begin
                                r_t    <= r_t + r_qd;
                                r_trem <= n_sum[SEG_W-1:0];
                            end
                            r_j     <= r_j + SEG_W'(1);
                            r_ax    <= 2'd0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_smp.valid       = r_oval;
    assign o_smp.sample_x    = r_smp[0];
    assign o_smp.sample_y    = r_smp[1];
    assign o_smp.sample_z    = r_smp[2];
    assign o_smp.last_sample = (r_j == r_n);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? {{(32-SEG_W){1'b0}}, r_seg} : 32'd0;

    // no sample is offered while a new point can be taken
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_smp.valid |-> !i_pt.ready)
        else $error("point ready while a sample is pending");

    // the final sample transfer of a run frees the input
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_smp.valid && o_smp.ready && o_smp.last_sample) |=> i_pt.ready)
        else $error("input not ready after last sample");

    // a point that does not complete a window of four leaves the block idle
    a_short_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready && (i_pt.start_curve || r_held != 2'd3))
        |=> (i_pt.ready && !o_smp.valid))
        else $error("segment started with fewer than four points");

endmodule
